@@ rtl/core/csrrb_pkg.sv @@
// Shared types, codes and defaults for the CSR row builder and reader.
package csrrb_pkg;

    localparam int MAX_DIM_DEF      = 64;
    localparam int MAX_NONZEROS_DEF = 1024;

    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int VAL_W = 32;
    localparam int DIM_W = 7;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] element_value;
        logic                    end_of_row;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        out_column;
        logic signed [VAL_W-1:0] out_value;
        logic                    entry_valid;
        logic                    last;
        logic [1:0]              status;
    } out_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
    } entry_t;

endpackage

@@ rtl/core/csrrb_entry_mem.sv @@
// Column and value store: one write port, one registered read port with enable.
module csrrb_entry_mem #(
    parameter int DEPTH = csrrb_pkg::MAX_NONZEROS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  csrrb_pkg::entry_t    wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output csrrb_pkg::entry_t    rd_data
);

    csrrb_pkg::entry_t mem [DEPTH];
    csrrb_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/csr_row_builder_and_reader.sv @@
// CSR matrix builder and row reader.
// Insert or out-of-range read: result registered at the accepting edge, one transaction a cycle
// while the output is not stalled. Row read of n entries (n at most MAX_DIM): pointer read,
// pointer check, entry read, then one entry per cycle unless the output stalls; no new
// transaction until the row is done. Empty row: one result, registered in the pointer check.
// Reset: row pointer valid bits, count and open row cleared, dimension 64; entry store kept.
module csr_row_builder_and_reader #(
    parameter int MAX_DIM      = csrrb_pkg::MAX_DIM_DEF,
    parameter int MAX_NONZEROS = csrrb_pkg::MAX_NONZEROS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [csrrb_pkg::DIM_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  csrrb_pkg::in_item_t               s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output csrrb_pkg::out_item_t              m_item
);

    localparam int PW  = $clog2(MAX_NONZEROS + 1);
    localparam int AW  = $clog2(MAX_NONZEROS);
    localparam int PAW = $clog2(MAX_DIM + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PTR    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [csrrb_pkg::DIM_W-1:0]         dimension_reg;
    logic [PW-1:0]                       count_reg, count_next;
    logic [csrrb_pkg::ROW_W-1:0]         current_row_reg, current_row_next;
    logic                                inside_row_reg, inside_row_next;
    logic [MAX_DIM:0]                    rp_vld_reg;

    logic [PW-1:0]                       rp_mem [MAX_DIM + 1];
    logic [PW-1:0]                       rp_start_reg, rp_end_reg;
    logic                                vld_start_reg, vld_end_reg;

    logic [PW-1:0]                       addr_reg, addr_next;
    logic [PAW-1:0]                      left_reg, left_next;
    logic                                pend_reg, pend_next;
    logic                                pend_last_reg, pend_last_next;

    logic                                m_valid_reg, m_valid_next;
    csrrb_pkg::out_item_t                m_item_reg, m_item_next;

    logic [csrrb_pkg::DIM_W-1:0]         eff_dim;
    logic                                out_free, accept, is_insert, is_read;
    logic [csrrb_pkg::ROW_W-1:0]         row_eff;
    logic                                ins_in_range, rd_in_range, nonzero, full;
    logic                                ent_wr_en, rp_wr_en, rp_rd_en;
    logic [PAW-1:0]                      rp_wr_addr, rd_addr_a, rd_addr_b;
    logic [PW-1:0]                       ptr_start, ptr_end, ptr_diff;
    logic                                out_load, issue;
    csrrb_pkg::entry_t                   ent_wr_data, ent_rd_data;
    logic [1:0]                          ins_status;

    always_comb begin
        if (dimension_reg == '0) begin
            eff_dim = csrrb_pkg::DIM_W'(1);
        end else if (32'(dimension_reg) > 32'(MAX_DIM)) begin
            eff_dim = csrrb_pkg::DIM_W'(MAX_DIM);
        end else begin
            eff_dim = dimension_reg;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign is_insert = accept && (s_item.operation == csrrb_pkg::OP_INSERT);
    assign is_read   = accept && (s_item.operation == csrrb_pkg::OP_READ);

    assign row_eff      = inside_row_reg ? current_row_reg : s_item.row_index;
    assign ins_in_range = {1'b0, row_eff} < eff_dim;
    assign rd_in_range  = {1'b0, s_item.row_index} < eff_dim;
    assign nonzero      = s_item.element_value != '0;
    assign full         = count_reg == PW'(MAX_NONZEROS);

    assign ent_wr_en          = is_insert && ins_in_range && nonzero && !full;
    assign ent_wr_data.column = s_item.column;
    assign ent_wr_data.value  = s_item.element_value;

    assign rp_wr_en   = is_insert && s_item.end_of_row && ins_in_range;
    assign rp_wr_addr = PAW'({1'b0, row_eff}) + PAW'(1);
    assign rp_rd_en   = is_read && rd_in_range;
    assign rd_addr_a  = PAW'({1'b0, s_item.row_index});
    assign rd_addr_b  = PAW'({1'b0, s_item.row_index}) + PAW'(1);

    always_comb begin
        if (!ins_in_range) begin
            ins_status = csrrb_pkg::ST_RANGE;
        end else if (nonzero && full) begin
            ins_status = csrrb_pkg::ST_FULL;
        end else begin
            ins_status = csrrb_pkg::ST_OK;
        end
    end

    // Row pointer store: write at insert end of row, two reads per lookup.
    always_ff @(posedge aclk) begin
        if (rp_wr_en) begin
            rp_mem[rp_wr_addr] <= count_next;
        end
        if (rp_rd_en) begin
            rp_start_reg  <= rp_mem[rd_addr_a];
            rp_end_reg    <= rp_mem[rd_addr_b];
            vld_start_reg <= rp_vld_reg[rd_addr_a];
            vld_end_reg   <= rp_vld_reg[rd_addr_b];
        end
    end

    assign ptr_start = vld_start_reg ? rp_start_reg : '0;
    assign ptr_end   = vld_end_reg ? rp_end_reg : '0;
    assign ptr_diff  = ptr_end - ptr_start;

    assign out_load = pend_reg && out_free;
    assign issue    = (state_reg == S_STREAM) && (left_reg != '0) && (!pend_reg || out_load);

    csrrb_entry_mem #(
        .DEPTH (MAX_NONZEROS),
        .AW    (AW)
    ) u_entry_mem (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ent_wr_data),
        .rd_en   (issue),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (ent_rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        current_row_next = current_row_reg;
        inside_row_next  = inside_row_reg;
        addr_next        = addr_reg;
        left_next        = left_reg;
        pend_next        = pend_reg;
        pend_last_next   = pend_last_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_item_next      = m_item_reg;

        if (ent_wr_en) begin
            count_next = count_reg + PW'(1);
        end

        if (is_insert) begin
            if (s_item.end_of_row) begin
                inside_row_next = 1'b0;
            end else begin
                inside_row_next  = 1'b1;
                current_row_next = row_eff;
            end
            m_valid_next            = 1'b1;
            m_item_next.out_column  = '0;
            m_item_next.out_value   = '0;
            m_item_next.entry_valid = 1'b0;
            m_item_next.last        = 1'b1;
            m_item_next.status      = ins_status;
        end

        if (is_read) begin
            if (rd_in_range) begin
                state_next = S_PTR;
            end else begin
                m_valid_next            = 1'b1;
                m_item_next.out_column  = '0;
                m_item_next.out_value   = '0;
                m_item_next.entry_valid = 1'b0;
                m_item_next.last        = 1'b1;
                m_item_next.status      = csrrb_pkg::ST_RANGE;
            end
        end

        case (state_reg)
            S_IDLE: begin
            end
            S_PTR: begin
                if (ptr_end <= ptr_start) begin
                    if (out_free) begin
                        m_valid_next            = 1'b1;
                        m_item_next.out_column  = '0;
                        m_item_next.out_value   = '0;
                        m_item_next.entry_valid = 1'b0;
                        m_item_next.last        = 1'b1;
                        m_item_next.status      = csrrb_pkg::ST_OK;
                        state_next              = S_IDLE;
                    end
                end else begin
                    addr_next  = ptr_start;
                    left_next  = (32'(ptr_diff) > 32'(MAX_DIM)) ? PAW'(MAX_DIM) : PAW'(ptr_diff);
                    pend_next  = 1'b0;
                    state_next = S_STREAM;
                end
            end
            S_STREAM: begin
                if (out_load) begin
                    m_valid_next            = 1'b1;
                    m_item_next.out_column  = ent_rd_data.column;
                    m_item_next.out_value   = ent_rd_data.value;
                    m_item_next.entry_valid = 1'b1;
                    m_item_next.last        = pend_last_reg;
                    m_item_next.status      = csrrb_pkg::ST_OK;
                    pend_next               = 1'b0;
                end
                if (issue) begin
                    addr_next      = addr_reg + PW'(1);
                    left_next      = left_reg - PAW'(1);
                    pend_next      = 1'b1;
                    pend_last_next = left_reg == PAW'(1);
                end
                if ((left_reg == '0) && (!pend_reg || out_load)) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            dimension_reg   <= csrrb_pkg::DIM_RESET;
            count_reg       <= '0;
            current_row_reg <= '0;
            inside_row_reg  <= 1'b0;
            rp_vld_reg      <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            current_row_reg <= current_row_next;
            inside_row_reg  <= inside_row_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                dimension_reg <= cfg_wr_data;
            end
            if (rp_wr_en) begin
                rp_vld_reg[rp_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        left_reg      <= left_next;
        pend_last_reg <= pend_last_next;
        m_item_reg    <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
